### rtl/scv_pkg.sv
package scv_pkg;

    localparam int DEF_NAME_BYTES   = 32;
    localparam int DEF_ENTRY_COUNT  = 16;
    localparam int DEF_DIGEST_BYTES = 32;
    localparam int DEF_HEADER_BYTES = 8;

    localparam logic [15:0] VERSION_RESET = 16'd1;
    localparam logic [31:0] SUFFIX_WORD   = 32'h2E77706B;  // ".wpk"
    localparam int          MIN_NAME_LEN  = 5;

    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    localparam logic [1:0] PART_HEADER = 2'd0;
    localparam logic [1:0] PART_NAME   = 2'd1;
    localparam logic [1:0] PART_DIGEST = 2'd2;
    localparam logic [1:0] PART_PAST   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_NAME   = 2'd2;

    localparam logic [1:0] ORD_EQUAL   = 2'd0;
    localparam logic [1:0] ORD_LESS    = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_NAME   = 4'b0010,
        PH_DIGEST = 4'b0100,
        PH_PAST   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] catalog_byte;
        logic       last_byte;
    } scv_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] byte_part;
        logic [3:0] entry_index;
        logic [4:0] byte_offset;
        logic       final_flag;
        logic [1:0] status;
    } scv_out_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h57;
            2'd1:    m = 8'h46;
            2'd2:    m = 8'h53;
            default: m = 8'h31;
        endcase
        return m;
    endfunction

    function automatic logic char_allowed(input logic [7:0] b);
        return (b >= CH_LOW_A && b <= CH_LOW_Z) ||
               (b >= CH_DIG_0 && b <= CH_DIG_9) ||
               b == CH_DASH || b == CH_UNDER || b == CH_DOT;
    endfunction

endpackage

### rtl/seed_catalog_validator_top.sv
// Streams a catalog image one byte per request and returns one result per byte:
// the byte itself, tagged with its part (header, filename, digest or past the
// expected end), record number and offset. The result that carries the last
// byte also carries the verdict: format error for a wrong length or header,
// otherwise filename error for a bad or out-of-order name, otherwise ok. A byte
// can be taken every cycle; each result appears in the cycle after its request
// is taken, through the output register, and no byte is taken while that
// register holds a result the sink is not accepting in the same cycle. The
// previous filename sits in a small RAM read ahead of use; no cycle is lost to it.
module seed_catalog_validator_top #(
    parameter int NAME_BYTES   = scv_pkg::DEF_NAME_BYTES,
    parameter int ENTRY_COUNT  = scv_pkg::DEF_ENTRY_COUNT,
    parameter int DIGEST_BYTES = scv_pkg::DEF_DIGEST_BYTES,
    parameter int HEADER_BYTES = scv_pkg::DEF_HEADER_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  scv_pkg::scv_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output scv_pkg::scv_out_t m_item,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata
);

    logic              accept;
    logic              m_valid_reg;
    scv_pkg::scv_out_t m_item_reg;
    scv_pkg::scv_out_t result;
    logic [15:0]       version_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= scv_pkg::VERSION_RESET;
        end else if (cfg_we) begin
            version_reg <= cfg_wdata;
        end
    end

    scv_parser #(
        .NAME_BYTES   (NAME_BYTES),
        .ENTRY_COUNT  (ENTRY_COUNT),
        .DIGEST_BYTES (DIGEST_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .item             (s_item),
        .expected_version (version_reg),
        .result           (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg <= result;
        end
    end

    a_status_only_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_item_reg.final_flag |-> m_item_reg.status == scv_pkg::ST_OK)
        else $error("status set on a non-final result");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_item_reg.status != 2'd3)
        else $error("undefined status code");

    a_past_untagged: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.byte_part == scv_pkg::PART_PAST |->
            m_item_reg.entry_index == 4'd0 && m_item_reg.byte_offset == 5'd0)
        else $error("byte past the end carries a position");

    a_header_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.byte_part == scv_pkg::PART_HEADER |->
            m_item_reg.entry_index == 4'd0)
        else $error("header byte tagged with a record number");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg && m_item_reg.data_byte == $past(s_item.catalog_byte))
        else $error("accepted byte not passed to the output");

endmodule

### rtl/scv_name_mem.sv
module scv_name_mem #(
    parameter int DEPTH = scv_pkg::DEF_NAME_BYTES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/scv_parser.sv
module scv_parser #(
    parameter int NAME_BYTES   = scv_pkg::DEF_NAME_BYTES,
    parameter int ENTRY_COUNT  = scv_pkg::DEF_ENTRY_COUNT,
    parameter int DIGEST_BYTES = scv_pkg::DEF_DIGEST_BYTES,
    parameter int HEADER_BYTES = scv_pkg::DEF_HEADER_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  scv_pkg::scv_in_t  item,
    input  logic [15:0]       expected_version,
    output scv_pkg::scv_out_t result
);

    localparam int MAX_PART = (NAME_BYTES > HEADER_BYTES) ?
        ((NAME_BYTES > DIGEST_BYTES) ? NAME_BYTES : DIGEST_BYTES) :
        ((HEADER_BYTES > DIGEST_BYTES) ? HEADER_BYTES : DIGEST_BYTES);
    localparam int OW = $clog2(MAX_PART);
    localparam int EW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int AW = $clog2(NAME_BYTES);

    scv_pkg::phase_t phase_reg, phase_next;
    logic [OW-1:0]   off_reg, off_next;
    logic [EW-1:0]   entry_reg, entry_next;
    logic            header_bad_reg, header_bad_next;
    logic            name_error_reg, name_error_next;
    logic [7:0]      word_low_reg, word_low_next;
    logic [1:0]      ord_reg, ord_next;
    logic [31:0]     suffix_reg, suffix_next;
    logic            term_reg, term_next;

    logic [7:0]      b;
    logic [7:0]      cur;
    logic [7:0]      prev;
    logic            length_ok;
    logic            mem_we;
    scv_pkg::phase_t rd_phase;
    logic [OW-1:0]   rd_off;
    logic [AW-1:0]   rd_addr;

    assign b = item.catalog_byte;

    always_comb begin
        phase_next      = phase_reg;
        off_next        = off_reg;
        entry_next      = entry_reg;
        header_bad_next = header_bad_reg;
        name_error_next = name_error_reg;
        word_low_next   = word_low_reg;
        ord_next        = ord_reg;
        suffix_next     = suffix_reg;
        term_next       = term_reg;
        cur             = term_reg ? 8'd0 : b;
        mem_we          = 1'b0;

        result.data_byte   = b;
        result.final_flag  = item.last_byte;
        result.status      = scv_pkg::ST_OK;
        result.byte_part   = scv_pkg::PART_PAST;
        result.entry_index = 4'(entry_reg);
        result.byte_offset = 5'(off_reg);

        case (phase_reg)
            scv_pkg::PH_HEADER: begin
                result.byte_part   = scv_pkg::PART_HEADER;
                result.entry_index = 4'd0;
                if (off_reg < OW'(4)) begin
                    if (b != scv_pkg::magic_byte(off_reg[1:0])) header_bad_next = 1'b1;
                end else if (off_reg == OW'(4) || off_reg == OW'(6)) begin
                    word_low_next = b;
                end else if (off_reg == OW'(5)) begin
                    if ({b, word_low_reg} != expected_version) header_bad_next = 1'b1;
                end else if (off_reg == OW'(7)) begin
                    if ({b, word_low_reg} != 16'(ENTRY_COUNT)) header_bad_next = 1'b1;
                end
                if (off_reg == OW'(HEADER_BYTES - 1)) begin
                    phase_next = scv_pkg::PH_NAME;
                    off_next   = '0;
                end else begin
                    off_next = off_reg + OW'(1);
                end
            end
            scv_pkg::PH_NAME: begin
                result.byte_part = scv_pkg::PART_NAME;
                mem_we           = accept;
                if (!term_reg) begin
                    if (b == 8'd0) begin
                        term_next = 1'b1;
                        if (off_reg < OW'(scv_pkg::MIN_NAME_LEN) ||
                            suffix_reg != scv_pkg::SUFFIX_WORD) begin
                            name_error_next = 1'b1;
                        end
                    end else begin
                        if (!scv_pkg::char_allowed(b)) name_error_next = 1'b1;
                        if (off_reg == '0 && b == scv_pkg::CH_DOT) name_error_next = 1'b1;
                        suffix_next = {suffix_reg[23:0], b};
                    end
                end else if (b != 8'd0) begin
                    name_error_next = 1'b1;
                end
                if (entry_reg != '0 && ord_reg == scv_pkg::ORD_EQUAL) begin
                    if (prev < cur) begin
                        ord_next = scv_pkg::ORD_LESS;
                    end else if (prev > cur) begin
                        ord_next = scv_pkg::ORD_GREATER;
                    end
                end
                if (off_reg == OW'(NAME_BYTES - 1)) begin
                    if (!term_next) name_error_next = 1'b1;
                    if (entry_reg != '0 && ord_next != scv_pkg::ORD_LESS) begin
                        name_error_next = 1'b1;
                    end
                    ord_next    = scv_pkg::ORD_EQUAL;
                    suffix_next = '0;
                    term_next   = 1'b0;
                    phase_next  = scv_pkg::PH_DIGEST;
                    off_next    = '0;
                end else begin
                    off_next = off_reg + OW'(1);
                end
            end
            scv_pkg::PH_DIGEST: begin
                result.byte_part = scv_pkg::PART_DIGEST;
                if (off_reg == OW'(DIGEST_BYTES - 1)) begin
                    off_next = '0;
                    if (entry_reg == EW'(ENTRY_COUNT - 1)) begin
                        phase_next = scv_pkg::PH_PAST;
                        entry_next = '0;
                    end else begin
                        phase_next = scv_pkg::PH_NAME;
                        entry_next = entry_reg + EW'(1);
                    end
                end else begin
                    off_next = off_reg + OW'(1);
                end
            end
            default: begin
                result.byte_part   = scv_pkg::PART_PAST;
                result.entry_index = 4'd0;
                result.byte_offset = 5'd0;
            end
        endcase

        length_ok = phase_reg == scv_pkg::PH_DIGEST &&
                    entry_reg == EW'(ENTRY_COUNT - 1) &&
                    off_reg == OW'(DIGEST_BYTES - 1);

        if (item.last_byte) begin
            if (!length_ok || header_bad_reg) begin
                result.status = scv_pkg::ST_FORMAT;
            end else if (name_error_reg) begin
                result.status = scv_pkg::ST_NAME;
            end
            phase_next      = scv_pkg::PH_HEADER;
            off_next        = '0;
            entry_next      = '0;
            header_bad_next = 1'b0;
            name_error_next = 1'b0;
            word_low_next   = '0;
            ord_next        = scv_pkg::ORD_EQUAL;
            suffix_next     = '0;
            term_next       = 1'b0;
        end
    end

    // prefetch the previous name byte for the offset the next request will use
    always_comb begin
        rd_phase = accept ? phase_next : phase_reg;
        rd_off   = accept ? off_next : off_reg;
        rd_addr  = (rd_phase == scv_pkg::PH_NAME) ? rd_off[AW-1:0] : '0;
    end

    scv_name_mem #(
        .DEPTH (NAME_BYTES),
        .AW    (AW)
    ) u_name_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (off_reg[AW-1:0]),
        .wdata (cur),
        .raddr (rd_addr),
        .rdata (prev)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= scv_pkg::PH_HEADER;
            off_reg        <= '0;
            entry_reg      <= '0;
            header_bad_reg <= 1'b0;
            name_error_reg <= 1'b0;
            word_low_reg   <= '0;
            ord_reg        <= scv_pkg::ORD_EQUAL;
            suffix_reg     <= '0;
            term_reg       <= 1'b0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            off_reg        <= off_next;
            entry_reg      <= entry_next;
            header_bad_reg <= header_bad_next;
            name_error_reg <= name_error_next;
            word_low_reg   <= word_low_next;
            ord_reg        <= ord_next;
            suffix_reg     <= suffix_next;
            term_reg       <= term_next;
        end
    end

endmodule

### bench/seed_catalog_validator_top_test.sv
module seed_catalog_validator_top_test;
    import scv_pkg::*;

    localparam int NAME_BYTES   = DEF_NAME_BYTES;
    localparam int ENTRY_COUNT  = DEF_ENTRY_COUNT;
    localparam int DIGEST_BYTES = DEF_DIGEST_BYTES;
    localparam int HEADER_BYTES = DEF_HEADER_BYTES;
    localparam int RECORD_BYTES = NAME_BYTES + DIGEST_BYTES;
    localparam int TOTAL_BYTES  = HEADER_BYTES + ENTRY_COUNT * RECORD_BYTES;

    localparam logic [31:0] MAGIC_WORD = "WFS1";

    typedef enum int {
        CAT_CLEAN,
        CAT_NAME_ERR,
        CAT_HDR_ERR,
        CAT_LONG,
        CAT_SHORT,
        CAT_NOISE
    } catalog_kind_t;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        logic       typed;
        logic [1:0] part;
        logic [3:0] rec;
        logic [4:0] offs;
        logic [1:0] st;
    } probe_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    scv_in_t     s_item;
    logic        m_valid;
    logic        m_ready;
    scv_out_t    m_item;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    int send_idle = 33;
    int recv_idle = 75;
    int bytes_sent = 0;
    int tag_mismatches = 0;

    scv_out_t tags_due [$];
    scv_out_t tag_want;

    // shadow of the stream state
    logic [15:0] version_reg = VERSION_RESET;
    logic [10:0] pos_cnt     = '0;
    logic [7:0]  ver_low     = '0;
    logic        hdr_bad     = 1'b0;
    logic        name_bad    = 1'b0;
    logic        term_seen   = 1'b0;
    logic [1:0]  name_order  = ORD_EQUAL;
    logic [31:0] tail_chars  = '0;
    logic [7:0]  last_name [NAME_BYTES] = '{default: 8'h00};

    logic [7:0] name_chars [$];
    logic [7:0] rec_names [ENTRY_COUNT][NAME_BYTES];
    logic [7:0] cat_img [$];

    probe_row_t probe_table [17] = '{
        '{8'h00, 1'b1, 1'b1, PART_HEADER, 4'd0, 5'd0, ST_FORMAT},
        '{8'hFF, 1'b1, 1'b1, PART_HEADER, 4'd0, 5'd0, ST_FORMAT},
        '{MAGIC_WORD[31:24], 1'b0, 1'b1, PART_HEADER, 4'd0, 5'd0, ST_OK},
        '{MAGIC_WORD[23:16], 1'b0, 1'b1, PART_HEADER, 4'd0, 5'd1, ST_OK},
        '{MAGIC_WORD[15:8],  1'b0, 1'b1, PART_HEADER, 4'd0, 5'd2, ST_OK},
        '{MAGIC_WORD[7:0],   1'b0, 1'b1, PART_HEADER, 4'd0, 5'd3, ST_OK},
        '{8'h01, 1'b0, 1'b1, PART_HEADER, 4'd0, 5'd4, ST_OK},
        '{8'h00, 1'b0, 1'b1, PART_HEADER, 4'd0, 5'd5, ST_OK},
        '{8'h10, 1'b0, 1'b1, PART_HEADER, 4'd0, 5'd6, ST_OK},
        '{8'h00, 1'b0, 1'b1, PART_HEADER, 4'd0, 5'd7, ST_OK},
        '{CH_LOW_A, 1'b0, 1'b0, PART_NAME, 4'd0, 5'd0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, PART_NAME, 4'd0, 5'd1, ST_OK},
        '{8'h00, 1'b0, 1'b0, PART_NAME, 4'd0, 5'd2, ST_OK},
        '{8'h00, 1'b1, 1'b1, PART_NAME, 4'd0, 5'd3, ST_FORMAT},
        '{MAGIC_WORD[31:24], 1'b0, 1'b1, PART_HEADER, 4'd0, 5'd0, ST_OK},
        '{8'h80, 1'b0, 1'b1, PART_HEADER, 4'd0, 5'd1, ST_OK},
        '{8'h7F, 1'b1, 1'b1, PART_HEADER, 4'd0, 5'd2, ST_FORMAT}
    };

    seed_catalog_validator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic scv_out_t tag_byte(input logic [7:0] b, input logic fin);
        scv_out_t   r;
        int         pos;
        int         rel;
        int         rec;
        int         offs;
        logic [7:0] cur;
        pos = int'(pos_cnt);
        rec = 0;
        offs = 0;
        r.data_byte = b;
        r.byte_part = PART_PAST;
        r.final_flag = fin;
        r.status = ST_OK;
        if (pos < TOTAL_BYTES) begin
            if (pos < HEADER_BYTES) begin
                r.byte_part = PART_HEADER;
                offs = pos;
                if (offs < 4) begin
                    if (b != MAGIC_WORD[31 - 8 * offs -: 8]) hdr_bad = 1'b1;
                end else if (offs == 4 || offs == 6) begin
                    ver_low = b;
                end else if (offs == 5) begin
                    if ({b, ver_low} != version_reg) hdr_bad = 1'b1;
                end else if (offs == 7) begin
                    if ({b, ver_low} != 16'(ENTRY_COUNT)) hdr_bad = 1'b1;
                end
            end else begin
                rel = pos - HEADER_BYTES;
                rec = rel / RECORD_BYTES;
                offs = rel % RECORD_BYTES;
                if (offs < NAME_BYTES) begin
                    r.byte_part = PART_NAME;
                    if (!term_seen) begin
                        if (b == 8'h00) begin
                            term_seen = 1'b1;
                            if (offs < MIN_NAME_LEN || tail_chars != SUFFIX_WORD) name_bad = 1'b1;
                        end else begin
                            if (!((b >= CH_LOW_A && b <= CH_LOW_Z) ||
                                  (b >= CH_DIG_0 && b <= CH_DIG_9) ||
                                  b == CH_DASH || b == CH_UNDER || b == CH_DOT))
                                name_bad = 1'b1;
                            if (offs == 0 && b == CH_DOT) name_bad = 1'b1;
                            tail_chars = {tail_chars[23:0], b};
                        end
                    end else if (b != 8'h00) begin
                        name_bad = 1'b1;
                    end
                    cur = term_seen ? 8'h00 : b;
                    if (rec != 0 && name_order == ORD_EQUAL) begin
                        if (last_name[offs] < cur) name_order = ORD_LESS;
                        else if (last_name[offs] > cur) name_order = ORD_GREATER;
                    end
                    last_name[offs] = cur;
                    if (offs == NAME_BYTES - 1) begin
                        if (!term_seen) name_bad = 1'b1;
                        if (rec != 0 && name_order != ORD_LESS) name_bad = 1'b1;
                        name_order = ORD_EQUAL;
                        tail_chars = '0;
                        term_seen = 1'b0;
                    end
                end else begin
                    r.byte_part = PART_DIGEST;
                    offs -= NAME_BYTES;
                end
            end
            pos_cnt = 11'(pos + 1);
        end
        if (fin) begin
            if (pos + 1 != TOTAL_BYTES || hdr_bad) r.status = ST_FORMAT;
            else if (name_bad) r.status = ST_NAME;
            pos_cnt = '0;
            ver_low = '0;
            hdr_bad = 1'b0;
            name_bad = 1'b0;
            name_order = ORD_EQUAL;
            tail_chars = '0;
            term_seen = 1'b0;
        end
        r.entry_index = 4'(rec);
        r.byte_offset = 5'(offs);
        return r;
    endfunction

    function automatic logic [7:0] any_name_char();
        return ($urandom_range(38) == 0) ? CH_DOT : name_chars[$urandom_range(0, 37)];
    endfunction

    // names climb by their first two characters, or extend the previous name
    // with a character above '.', so a clean catalog is strictly ordered
    task automatic build_catalog(input catalog_kind_t kind);
        logic [7:0] body [$];
        logic [7:0] tmp [NAME_BYTES];
        logic [7:0] c;
        int         v;
        int         room;
        int         n;
        int         j;
        int         o;
        int         tlen;
        v = $urandom_range(0, 60);
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            room = 27 - body.size();
            if (i > 0 && room > 0 && $urandom_range(3) == 0) begin
                n = $urandom_range(1, (room < 4) ? room : 4);
                body.push_back(name_chars[$urandom_range(1, 37)]);
                repeat (n - 1) body.push_back(any_name_char());
            end else begin
                if (i > 0) v += $urandom_range(1, 80);
                body.delete();
                body.push_back(name_chars[v / 38]);
                body.push_back(name_chars[v % 38]);
                n = ($urandom_range(7) == 0) ? $urandom_range(0, 25) : $urandom_range(0, 4);
                repeat (n) body.push_back(any_name_char());
            end
            for (int k = 0; k < NAME_BYTES; k++) rec_names[i][k] = 8'h00;
            foreach (body[q]) rec_names[i][q] = body[q];
            for (int k = 0; k < 4; k++) rec_names[i][body.size() + k] = SUFFIX_WORD[31 - 8 * k -: 8];
        end

        if (kind == CAT_NAME_ERR) begin
            j = $urandom_range(0, ENTRY_COUNT - 1);
            tlen = 0;
            while (rec_names[j][tlen] != 8'h00) tlen++;
            case ($urandom_range(0, 7))
                0: for (int k = 0; k < NAME_BYTES; k++) rec_names[j][k] = any_name_char();
                1: for (int k = 0; k < NAME_BYTES; k++) rec_names[j][k] = 8'h00;
                2: rec_names[j][0] = CH_DOT;
                3: begin
                    n = $urandom_range(1, 4);
                    for (int k = 0; k < NAME_BYTES; k++)
                        rec_names[j][k] = (k < n) ? name_chars[$urandom_range(0, 37)] : 8'h00;
                end
                4: rec_names[j][tlen - 1 - $urandom_range(0, 3)] = name_chars[$urandom_range(0, 37)];
                5: begin
                    case ($urandom_range(0, 3))
                        0:       c = 8'($urandom_range(8'h01, 8'h2C));
                        1:       c = 8'($urandom_range(8'h3A, 8'h5E));
                        2:       c = 8'($urandom_range(8'h7B, 8'hFF));
                        default: c = 8'h2F;
                    endcase
                    rec_names[j][$urandom_range(0, tlen - 1)] = c;
                end
                6: begin
                    if (tlen < NAME_BYTES - 1)
                        rec_names[j][$urandom_range(tlen + 1, NAME_BYTES - 1)] =
                            8'($urandom_range(1, 255));
                    else
                        rec_names[j][tlen] = name_chars[0];
                end
                default: begin
                    o = (j == 0) ? 1 : j - 1;
                    for (int k = 0; k < NAME_BYTES; k++) tmp[k] = rec_names[j][k];
                    for (int k = 0; k < NAME_BYTES; k++) rec_names[j][k] = rec_names[o][k];
                    if ($urandom_range(1) == 1)
                        for (int k = 0; k < NAME_BYTES; k++) rec_names[o][k] = tmp[k];
                end
            endcase
        end

        cat_img.delete();
        for (int k = 0; k < 4; k++) cat_img.push_back(MAGIC_WORD[31 - 8 * k -: 8]);
        cat_img.push_back(version_reg[7:0]);
        cat_img.push_back(version_reg[15:8]);
        cat_img.push_back(8'(ENTRY_COUNT));
        cat_img.push_back(8'(ENTRY_COUNT >> 8));
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            for (int k = 0; k < NAME_BYTES; k++) cat_img.push_back(rec_names[i][k]);
            repeat (DIGEST_BYTES) cat_img.push_back(8'($urandom));
        end

        case (kind)
            CAT_HDR_ERR: begin
                o = $urandom_range(0, HEADER_BYTES - 1);
                cat_img[o] = cat_img[o] ^ 8'(1 << $urandom_range(0, 7));
            end
            CAT_LONG: repeat ($urandom_range(1, 6)) cat_img.push_back(8'($urandom));
            CAT_SHORT: begin
                n = $urandom_range(1, 300);
                while (cat_img.size() > n) void'(cat_img.pop_back());
            end
            CAT_NOISE: begin
                cat_img.delete();
                repeat ($urandom_range(1, 40)) cat_img.push_back(8'($urandom));
            end
            default: ;
        endcase
    endtask

    task automatic send_request(input logic [7:0] b, input logic fin, input logic use_typed,
                                input scv_out_t typed_want);
        scv_out_t want;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= '{catalog_byte: b, last_byte: fin};
        do @(posedge aclk); while (!s_ready);
        want = tag_byte(b, fin);
        tags_due.push_back(use_typed ? typed_want : want);
        bytes_sent++;
    endtask

    task automatic send_catalog();
        foreach (cat_img[i]) send_request(cat_img[i], i == cat_img.size() - 1, 1'b0, '0);
    endtask

    task automatic run_broken(input int amount);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < amount) begin
            build_catalog(($urandom_range(3) == 0) ? CAT_NOISE : CAT_SHORT);
            send_catalog();
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (tags_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_version(input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        version_reg = v;
    endtask

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (tags_due.size() == 0) begin
                if (tag_mismatches < 10)
                    $display("unexpected result: byte %h part %0d entry %0d off %0d fin %b st %0d",
                             m_item.data_byte, m_item.byte_part, m_item.entry_index,
                             m_item.byte_offset, m_item.final_flag, m_item.status);
                tag_mismatches++;
            end else begin
                tag_want = tags_due.pop_front();
                if (m_item !== tag_want) begin
                    if (tag_mismatches < 10) begin
                        $write("mismatch: exp byte %h part %0d entry %0d off %0d fin %b st %0d, ",
                               tag_want.data_byte, tag_want.byte_part, tag_want.entry_index,
                               tag_want.byte_offset, tag_want.final_flag, tag_want.status);
                        $display("got byte %h part %0d entry %0d off %0d fin %b st %0d",
                                 m_item.data_byte, m_item.byte_part, m_item.entry_index,
                                 m_item.byte_offset, m_item.final_flag, m_item.status);
                    end
                    tag_mismatches++;
                end
            end
        end
    end

    initial begin
        scv_out_t row_want;
        int       pick;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;

        name_chars.push_back(CH_DASH);
        for (int c = CH_DIG_0; c <= CH_DIG_9; c++) name_chars.push_back(8'(c));
        name_chars.push_back(CH_UNDER);
        for (int c = CH_LOW_A; c <= CH_LOW_Z; c++) name_chars.push_back(8'(c));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probe_table[i]) begin
            row_want = '{probe_table[i].b, probe_table[i].part, probe_table[i].rec,
                         probe_table[i].offs, probe_table[i].fin, probe_table[i].st};
            send_request(probe_table[i].b, probe_table[i].fin, probe_table[i].typed, row_want);
        end

        settle();
        write_version(16'hFFFF);
        run_broken(200);

        settle();
        send_idle = 75;
        recv_idle = 33;
        write_version(16'h0000);
        run_broken(150);

        settle();
        send_idle = 0;
        recv_idle = 0;
        write_version(16'($urandom));
        pick = $urandom_range(0, 7);
        build_catalog((pick == 0) ? CAT_HDR_ERR : (pick == 1) ? CAT_LONG :
                      (pick < 5) ? CAT_NAME_ERR : CAT_CLEAN);
        send_catalog();
        run_broken(50);

        settle();
        repeat (8) @(posedge aclk);
        if (tag_mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
rtl/scv_pkg.sv
rtl/scv_name_mem.sv
rtl/scv_parser.sv
rtl/seed_catalog_validator_top.sv
bench/seed_catalog_validator_top_test.sv
